// ===== rtl/lcbe_pkg.sv =====
// shared types and constants for the lru cache with batch eviction
`default_nettype none

package lcbe_pkg;

    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_PUT   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [6:0] CAP_RESET = 7'd64;

    // capacity / 10 as (capacity * 205) >> 11, exact for 7-bit capacity
    localparam logic [14:0] BATCH_MUL   = 15'd205;
    localparam int          BATCH_SHIFT = 11;

    typedef struct packed {
        logic compare;
        logic shift_all;
        logic shift_hit;
    } lcbe_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/lcbe_cell.sv =====
// one recency-ordered entry of the cache chain
`default_nettype none

module lcbe_cell #(
    parameter int IDX        = 0,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32,
    parameter int IW         = 6,
    parameter int CW         = 7
) (
    input  wire logic                          clk,
    input  wire lcbe_pkg::lcbe_cell_ctrl_t     ctrl,
    input  wire logic [KEY_BITS-1:0]           probe_key,
    input  wire logic [CW-1:0]                 limit,
    input  wire logic [IW-1:0]                 pos,
    input  wire logic [KEY_BITS-1:0]           prev_key,
    input  wire logic [VALUE_BITS-1:0]         prev_value,
    output logic      [KEY_BITS-1:0]           key,
    output logic      [VALUE_BITS-1:0]         value,
    output logic                               match
);
    import lcbe_pkg::*;

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  key_eq_reg;
    logic                  live;
    logic                  load;

    assign live  = CW'(IDX) < limit;
    assign match = key_eq_reg & live;
    assign load  = ctrl.shift_all | (ctrl.shift_hit & (IW'(IDX) <= pos));
    assign key   = key_reg;
    assign value = value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.compare)
        begin
            key_eq_reg <= (key_reg == probe_key);
        end
        if (load)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lru_cache_batch_evict_core.sv =====
// top level of the fully associative lru cache with batch eviction
`default_nettype none

// Fully associative key/value cache kept as a chain of cells ordered by recency:
// cell 0 holds the most recent entry, the last live cell the least recent one.
// Each item is handled as follows: in the accept cycle all cells compare their
// key against the incoming key in parallel; in the execute state the hit position
// is resolved, the chain shifts (from the hit cell toward the head, or the whole
// chain for a new key) and the result beat is loaded into the output register.
// A new item is taken in the cycle after that as long as the output register is
// free or being drained, but never while an item is in the execute state. Both
// capacity and batch evictions drop the tail of the chain by adjusting the
// occupancy count and need no extra state. Write capacity only while idle.
module lru_cache_batch_evict_core #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [63:0] key,
    input  wire logic [31:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [31:0]      read_value,
    output logic [6:0]       evicted_count,
    output logic [6:0]       occupancy,
    output logic [31:0]      hit_count,
    output logic [31:0]      miss_count
);
    import lcbe_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = $clog2(ENTRIES);
    localparam int WW = (CW > 7) ? CW : 7;
    localparam int VX = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg;
    logic [6:0]            capacity_reg;
    logic [CW-1:0]         total_reg;
    logic [CW-1:0]         limit_reg;
    logic [31:0]           hits_reg;
    logic [31:0]           misses_reg;
    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [31:0]           read_value_reg;
    logic [6:0]            evicted_reg;
    logic [6:0]            occupancy_reg;

    logic                  in_accept;
    logic [6:0]            cap_eff;
    logic [14:0]           batch_prod;
    logic [3:0]            batch_q;
    logic [3:0]            batch;
    logic [CW-1:0]         limit_next;
    logic [VX-1:0]         value_x;

    logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
    logic [VALUE_BITS-1:0] cell_value [ENTRIES];
    logic [ENTRIES-1:0]    match_vec;
    logic [IW-1:0]         pos_enc;
    logic [VALUE_BITS-1:0] sel_value;
    logic [VX-1:0]         sel_x;
    lcbe_cell_ctrl_t       cell_ctrl;
    logic [VALUE_BITS-1:0] head_value;

    logic                  exec;
    logic                  any_hit;
    logic                  is_get;
    logic                  is_put;
    logic                  is_clear;
    logic                  put_miss;
    logic [CW-1:0]         batch_cut;
    logic [CW-1:0]         pre_total;
    logic [CW-1:0]         total_next;
    logic [CW-1:0]         evicted_raw;
    logic [31:0]           hits_next;
    logic [31:0]           misses_next;

    assign cfg_ready  = 1'b1;
    assign in_accept  = in_valid & ~in_stall;
    assign in_stall   = (state_reg != ST_IDLE) | (out_valid_reg & out_stall);
    assign exec       = (state_reg == ST_EXEC);

    // effective capacity and batch size
    always_comb
    begin
        cap_eff = capacity_reg;
        if (capacity_reg == 7'd0)
        begin
            cap_eff = 7'd1;
        end
        else if (WW'(capacity_reg) > WW'(ENTRIES))
        begin
            cap_eff = 7'(ENTRIES);
        end
        batch_prod = 15'(cap_eff) * BATCH_MUL;
        batch_q    = 4'(batch_prod >> BATCH_SHIFT);
        batch      = (batch_q == 4'd0) ? 4'd1 : batch_q;
        limit_next = (WW'(total_reg) < WW'(cap_eff)) ? total_reg : CW'(cap_eff);
    end

    assign value_x = VX'(value);

    // hit resolve
    always_comb
    begin
        pos_enc   = '0;
        sel_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                pos_enc   = pos_enc | IW'(i);
                sel_value = sel_value | cell_value[i];
            end
        end
    end

    assign sel_x    = VX'(sel_value);
    assign any_hit  = |match_vec;
    assign is_get   = (op_reg == OP_GET);
    assign is_put   = (op_reg == OP_PUT);
    assign is_clear = (op_reg == OP_CLEAR);
    assign put_miss = is_put & ~any_hit;

    assign cell_ctrl.compare   = in_accept;
    assign cell_ctrl.shift_all = exec & put_miss;
    assign cell_ctrl.shift_hit = exec & any_hit & (is_get | is_put);
    assign head_value          = is_put ? value_reg : sel_value;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            logic [KEY_BITS-1:0]   prev_key;
            logic [VALUE_BITS-1:0] prev_value;
            if (gi == 0)
            begin : g_head
                assign prev_key   = key_reg;
                assign prev_value = head_value;
            end
            else
            begin : g_body
                assign prev_key   = cell_key[gi-1];
                assign prev_value = cell_value[gi-1];
            end
            lcbe_cell #(
                .IDX        (gi),
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS),
                .IW         (IW),
                .CW         (CW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .probe_key  (key[KEY_BITS-1:0]),
                .limit      (limit_reg),
                .pos        (pos_enc),
                .prev_key   (prev_key),
                .prev_value (prev_value),
                .key        (cell_key[gi]),
                .value      (cell_value[gi]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    // occupancy and counter update
    always_comb
    begin
        batch_cut = (WW'(batch) < WW'(limit_reg)) ? CW'(batch) : limit_reg;
        pre_total = limit_reg;
        if (put_miss && (WW'(limit_reg) >= WW'(cap_eff)))
        begin
            pre_total = limit_reg - batch_cut;
        end
        evicted_raw = total_reg - pre_total;
        total_next  = pre_total;
        if (is_clear)
        begin
            total_next = '0;
        end
        else if (put_miss)
        begin
            total_next = pre_total + CW'(1);
        end
        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (is_clear)
        begin
            hits_next   = '0;
            misses_next = '0;
        end
        else if (is_get && any_hit)
        begin
            if (hits_reg != '1)
            begin
                hits_next = hits_reg + 32'd1;
            end
        end
        else if (is_get)
        begin
            if (misses_reg != '1)
            begin
                misses_next = misses_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_RESET;
            total_reg     <= '0;
            limit_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        limit_reg <= limit_next;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    total_reg     <= total_next;
                    limit_reg     <= '0;
                    hits_reg      <= hits_next;
                    misses_reg    <= misses_next;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= operation;
            key_reg   <= key[KEY_BITS-1:0];
            value_reg <= value_x[VALUE_BITS-1:0];
        end
        if (exec)
        begin
            hit_reg        <= any_hit & (is_get | is_put);
            read_value_reg <= (is_get && any_hit) ? sel_x[31:0] : 32'd0;
            evicted_reg    <= (WW'(evicted_raw) > WW'(127)) ? 7'd127 : 7'(evicted_raw);
            occupancy_reg  <= 7'(total_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            hit_count  <= hits_next;
            miss_count <= misses_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign read_value    = read_value_reg;
    assign evicted_count = evicted_reg;
    assign occupancy     = occupancy_reg;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(total_reg) <= WW'(ENTRIES))
        else $error("occupancy beyond entry count");

    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        exec |-> $onehot0(match_vec))
        else $error("key present in more than one cell");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        exec |-> !out_valid_reg)
        else $error("result beat overwritten");

    a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> exec && out_valid_reg == 1'b0)
        else $error("accepted item not executed");
`endif

endmodule

`default_nettype wire

// ===== test/lru_cache_batch_evict_core_test.sv =====
// testbench for the lru cache core: directed and random gets, puts and clears checked beat by beat
`default_nettype none

module lru_cache_batch_evict_core_test;
    import lcbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ENTRIES     = 64;
    localparam int          BATCH_DIV   = 10;
    localparam int          POOL_SIZE   = 128;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [1:0]  OP_SPARE    = 2'd3;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
        logic [31:0] value;
    } cache_req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic [6:0]  evicted;
        logic [6:0]  occupancy;
        logic [31:0] hits;
        logic [31:0] misses;
    } cache_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = OP_GET;
    logic [63:0] key = '0;
    logic [31:0] value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        hit;
    logic [31:0] read_value;
    logic [6:0]  evicted_count;
    logic [6:0]  occupancy;
    logic [31:0] hit_count;
    logic [31:0] miss_count;

    lru_cache_batch_evict_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .key           (key),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .read_value    (read_value),
        .evicted_count (evicted_count),
        .occupancy     (occupancy),
        .hit_count     (hit_count),
        .miss_count    (miss_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cache mirror
    logic [63:0] cache_key  [ENTRIES];
    logic [31:0] cache_val  [ENTRIES];
    bit          cache_live [ENTRIES];
    int          cache_rank [ENTRIES];
    int          cache_fill = 0;
    logic [31:0] hit_tally = '0;
    logic [31:0] miss_tally = '0;
    logic [6:0]  cap_reg = CAP_RESET;

    cache_req_t  pending_reqs [$];
    cache_resp_t expected_beats [$];
    cache_req_t  cur_req = '0;
    cache_resp_t exp_beat;
    logic [63:0] key_pool [POOL_SIZE];

    int  errors = 0;
    int  reqs_sent = 0;
    int  beats_seen = 0;
    int  evicting_reqs = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  calm = 1'b0;

    function automatic void drop_oldest();
        if (cache_fill == 0)
            return;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cache_live[i] && cache_rank[i] == cache_fill - 1)
            begin
                cache_live[i] = 1'b0;
                break;
            end
        end
        cache_fill--;
    endfunction

    function automatic int find_slot(input logic [63:0] k);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cache_live[i] && cache_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic void promote(input int slot);
        int r;
        r = cache_rank[slot];
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cache_live[i] && cache_rank[i] < r)
                cache_rank[i]++;
        end
        cache_rank[slot] = 0;
    endfunction

    function automatic void cache_apply(input cache_req_t rq);
        int          cap;
        int          evicted;
        int          slot;
        int          batch;
        int          free_slot;
        cache_resp_t rs;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
        evicted = 0;
        rs = '0;
        while (cache_fill > cap)
        begin
            drop_oldest();
            evicted++;
        end
        case (rq.op)
            OP_GET:
            begin
                slot = find_slot(rq.key);
                if (slot >= 0)
                begin
                    rs.hit = 1'b1;
                    rs.read_value = cache_val[slot];
                    promote(slot);
                    if (hit_tally != COUNT_MAX)
                        hit_tally++;
                end
                else if (miss_tally != COUNT_MAX)
                    miss_tally++;
            end
            OP_PUT:
            begin
                slot = find_slot(rq.key);
                if (slot >= 0)
                begin
                    rs.hit = 1'b1;
                    cache_val[slot] = rq.value;
                    promote(slot);
                end
                else
                begin
                    if (cache_fill >= cap)
                    begin
                        batch = cap / BATCH_DIV;
                        if (batch < 1)
                            batch = 1;
                        for (int i = 0; i < batch && cache_fill > 0; i++)
                        begin
                            drop_oldest();
                            evicted++;
                        end
                    end
                    free_slot = -1;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!cache_live[i])
                        begin
                            free_slot = i;
                            break;
                        end
                    end
                    if (free_slot >= 0)
                    begin
                        for (int j = 0; j < ENTRIES; j++)
                        begin
                            if (cache_live[j])
                                cache_rank[j]++;
                        end
                        cache_live[free_slot] = 1'b1;
                        cache_key[free_slot] = rq.key;
                        cache_val[free_slot] = rq.value;
                        cache_rank[free_slot] = 0;
                        cache_fill++;
                    end
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    cache_live[i] = 1'b0;
                cache_fill = 0;
                hit_tally = '0;
                miss_tally = '0;
            end
            default:
            begin
            end
        endcase
        if (evicted > 127)
            evicted = 127;
        if (evicted > 0)
            evicting_reqs++;
        rs.evicted = evicted[6:0];
        rs.occupancy = cache_fill[6:0];
        rs.hits = hit_tally;
        rs.misses = miss_tally;
        expected_beats.push_back(rs);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= OP_GET;
            key <= '0;
            value <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cache_apply(cur_req);
                reqs_sent++;
                send_gap = calm ? 0 : $urandom_range(0, 5);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    operation <= cur_req.op;
                    key <= cur_req.key;
                    value <= cur_req.value;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_seen++;
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    errors++;
                end
                else
                begin
                    exp_beat = expected_beats.pop_front();
                    check_field("hit", 32'(exp_beat.hit), 32'(hit));
                    check_field("read_value", exp_beat.read_value, read_value);
                    check_field("evicted_count", 32'(exp_beat.evicted), 32'(evicted_count));
                    check_field("occupancy", 32'(exp_beat.occupancy), 32'(occupancy));
                    check_field("hit_count", exp_beat.hits, hit_count);
                    check_field("miss_count", exp_beat.misses, miss_count);
                end
                recv_gap = calm ? 0 : $urandom_range(0, 5);
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic cache_req_t mk_req(input logic [1:0] op, input logic [63:0] k,
                                          input logic [31:0] v);
        cache_req_t rq;
        rq.op = op;
        rq.key = k;
        rq.value = v;
        return rq;
    endfunction

    function automatic cache_req_t random_req(input int pool_n, input int put_pct,
                                              input int clear_pct);
        cache_req_t rq;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < clear_pct)
            rq.op = OP_CLEAR;
        else if (roll < clear_pct + 2)
            rq.op = OP_SPARE;
        else if (roll < clear_pct + 2 + put_pct)
            rq.op = OP_PUT;
        else
            rq.op = OP_GET;
        if ($urandom_range(0, 9) == 0)
            rq.key = {$urandom, $urandom};
        else
            rq.key = key_pool[$urandom_range(0, pool_n - 1)];
        case ($urandom_range(0, 9))
            0: rq.value = '0;
            1: rq.value = '1;
            default: rq.value = $urandom;
        endcase
        return rq;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_beats.size() != 0);
    endtask

    task automatic write_capacity(input logic [6:0] cap);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_reg = cap;
        cfg_valid <= 1'b0;
    endtask

    logic [6:0] phase_caps [10] = '{7'd64, 7'd10, 7'd127, 7'd1, 7'd0,
                                    7'd33, 7'd2, 7'd64, 7'd5, 7'd20};

    initial
    begin
        int eff;
        int pool_n;
        int count;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset capacity
        @(negedge clk);
        pending_reqs.push_back(mk_req(OP_GET, key_pool[0], 32'h0));
        pending_reqs.push_back(mk_req(OP_PUT, key_pool[0], 32'h0));
        pending_reqs.push_back(mk_req(OP_PUT, key_pool[1], 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_req(OP_GET, key_pool[1], 32'h0));
        pending_reqs.push_back(mk_req(OP_GET, key_pool[0], 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_req(OP_PUT, key_pool[0], 32'h1234_5678));
        pending_reqs.push_back(mk_req(OP_GET, key_pool[0], 32'h0));
        pending_reqs.push_back(mk_req(OP_SPARE, key_pool[1], 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_req(OP_CLEAR, key_pool[0], 32'h0));
        pending_reqs.push_back(mk_req(OP_GET, key_pool[1], 32'h0));
        wait_drained();

        // small cache: batch of one on overflow
        write_capacity(7'd3);
        @(negedge clk);
        for (int i = 2; i < 6; i++)
            pending_reqs.push_back(mk_req(OP_PUT, key_pool[i], $urandom));
        pending_reqs.push_back(mk_req(OP_GET, key_pool[2], 32'h0));
        pending_reqs.push_back(mk_req(OP_GET, key_pool[3], 32'h0));
        pending_reqs.push_back(mk_req(OP_PUT, key_pool[6], $urandom));
        pending_reqs.push_back(mk_req(OP_GET, key_pool[4], 32'h0));
        wait_drained();

        // lowered below occupancy
        write_capacity(7'd1);
        @(negedge clk);
        pending_reqs.push_back(mk_req(OP_GET, key_pool[3], 32'h0));
        wait_drained();

        write_capacity(7'd0);
        @(negedge clk);
        pending_reqs.push_back(mk_req(OP_PUT, key_pool[7], 32'hA5A5_A5A5));
        pending_reqs.push_back(mk_req(OP_PUT, key_pool[7], 32'h5A5A_5A5A));
        pending_reqs.push_back(mk_req(OP_GET, key_pool[7], 32'h0));
        wait_drained();

        write_capacity(7'd127);
        @(negedge clk);
        pending_reqs.push_back(mk_req(OP_PUT, key_pool[8], $urandom));
        pending_reqs.push_back(mk_req(OP_GET, key_pool[8] ^ {1'b1, 63'h0}, 32'h0));
        wait_drained();

        // random phases
        for (int p = 0; p < 10; p++)
        begin
            write_capacity(phase_caps[p]);
            eff = (phase_caps[p] == 0) ? 1 :
                  ((phase_caps[p] > ENTRIES) ? ENTRIES : int'(phase_caps[p]));
            pool_n = eff + eff / 2 + 2;
            if (pool_n > POOL_SIZE)
                pool_n = POOL_SIZE;
            count = (p == 0) ? 100 : 33;
            @(negedge clk);
            calm = (p == 3 || p == 6);
            for (int i = 0; i < count; i++)
                pending_reqs.push_back(random_req(pool_n, (eff == ENTRIES) ? 60 : 45,
                                                  (p == 0) ? 0 : 3));
            if (p == 1)
                hold_req = 1'b1;
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("%0d requests sent, %0d result beats checked, %0d with evictions",
                 reqs_sent, beats_seen, evicting_reqs);
        $display("capacities 0 to 127 exercised, long output hold and calm phases included");
        if (errors == 0 && expected_beats.size() == 0)
            $display("== PASS ==");
        else
        begin
            if (expected_beats.size() != 0)
                $error("%0d expected results never arrived", expected_beats.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
